// File: design/rcdf_pkg.sv
// ----------------------------------------------------------------------------
// rcdf_pkg
// Shared types, constants and helper functions for the data packet framer.
// ----------------------------------------------------------------------------
`default_nettype none

package rcdf_pkg;

  // Channel store and hop sequence sizing
  localparam int NUM_RC_CHANNELS = 16;
  localparam int HOP_SLOTS       = 78;
  localparam int HOP_W           = $clog2(HOP_SLOTS);
  localparam int CH_SEL_W        = $clog2(NUM_RC_CHANNELS);
  localparam int SEND_CH_LIMIT   = 16;
  localparam int LANES           = 3;
  localparam int PKT_BYTES       = 8;

  // Field widths
  localparam int IDX_W   = 4;
  localparam int RAW_W   = 11;
  localparam int PHASE_W = 2;
  localparam int START_W = 5;
  localparam int VAL_W   = 16;
  localparam int BIDX_W  = $clog2(PKT_BYTES);

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_CRC_POLY   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SEED_OFFSET = 2'd1;

  // Phase codes (phase 3 behaves as the third slot)
  localparam logic [PHASE_W-1:0] PH_FIRST  = 2'd0;
  localparam logic [PHASE_W-1:0] PH_SECOND = 2'd1;

  // Header bytes
  localparam logic [7:0] HDR_BIND_EVEN = 8'h09;
  localparam logic [7:0] HDR_BIND_ODD  = 8'h01;
  localparam logic [7:0] HDR_HALF_HI   = 8'h02;
  localparam logic [7:0] HDR_HALF_LO   = 8'h0A;
  localparam logic [7:0] HDR_THIRD_EVN = 8'h88;
  localparam logic [7:0] HDR_THIRD_ODD = 8'h80;

  // Channel scaling: out = trunc((v - CH_MIN_100) * SPAN / DEN) + OUT_LO
  localparam int CH_MIN_100 = 204;
  localparam int CH_MAX_100 = 1844;
  localparam int OUT_LO     = 426;
  localparam int OUT_HI     = 3448;
  localparam int SCALE_SPAN = OUT_HI - OUT_LO;
  localparam int SCALE_DEN  = CH_MAX_100 - CH_MIN_100;
  localparam int MAG_W      = RAW_W;
  localparam int NUM_W      = 23;
  localparam int Q_W        = 12;

  // Division by SCALE_DEN as multiply by reciprocal; exact for NUM_W-bit numerators
  localparam int DIV_SHIFT = 33;
  localparam int RECIP_W   = 23;
  localparam logic [63:0] DIV_RECIP_FULL =
      ((64'd1 << DIV_SHIFT) + 64'(SCALE_DEN) - 64'd1) / 64'(SCALE_DEN);
  localparam logic [RECIP_W-1:0] DIV_RECIP = DIV_RECIP_FULL[RECIP_W-1:0];
  localparam int PROD_W = NUM_W + RECIP_W;

  typedef struct packed {
    logic                func;
    logic [IDX_W-1:0]    channel_index;
    logic [RAW_W-1:0]    channel_value;
    logic [PHASE_W-1:0]  phase;
    logic [HOP_W-1:0]    hop_slot;
  } item_t;

  // Front stage result: header, CRC seed and raw channel reads
  typedef struct packed {
    logic [7:0]                  hdr;
    logic [7:0]                  seed;
    logic [LANES-1:0][RAW_W-1:0] raw;
    logic [LANES-1:0]            ok;
  } front_t;

  // Pipeline load strobes for the scaling lanes
  typedef struct packed {
    logic load_c;
    logic load_d;
  } pipe_en_t;

  // Packet contents handed to the serializer
  typedef struct packed {
    logic [7:0]                  hdr;
    logic [7:0]                  seed;
    logic [LANES-1:0][VAL_W-1:0] val;
  } pkt_t;

  function automatic logic [7:0] rev8(input logic [7:0] x);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[i] = x[7-i];
    end
    return r;
  endfunction

  // hop mod 5 == 0, via reciprocal multiply (exact below 1024)
  function automatic logic hop_mod5_zero(input logic [HOP_W-1:0] h);
    logic [16:0] p;
    logic [6:0]  q;
    logic [9:0]  q5;
    p  = 17'(h) * 17'd205;
    q  = p[16:10];
    q5 = 10'(q) * 10'd5;
    return (10'(h) == q5);
  endfunction

endpackage

`default_nettype wire

// File: design/rcdf_front.sv
// ----------------------------------------------------------------------------
// rcdf_front
// Channel store, half toggle, header selection and channel reads.
// ----------------------------------------------------------------------------
`default_nettype none

module rcdf_front import rcdf_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire item_t       item,
  input  wire logic        wr_en,
  input  wire logic        load_b,
  input  wire logic [7:0]  seed_offset,
  output front_t           front_r
);

  logic [RAW_W-1:0] store_r [NUM_RC_CHANNELS];
  logic             toggle_r;
  logic             toggle_nxt;
  logic             toggle_eff;
  logic             flip;
  logic [7:0]       hdr;
  logic [START_W-1:0] start;
  front_t           front_nxt;
  logic [CH_SEL_W-1:0] widx;

  assign widx = CH_SEL_W'(item.channel_index);

  always_comb begin
    toggle_eff = (item.hop_slot == '0) ? 1'b1 : toggle_r;
    flip       = 1'b0;
    unique case (item.phase)
      PH_FIRST: begin
        hdr = item.hop_slot[0] ? HDR_BIND_ODD : HDR_BIND_EVEN;
      end
      PH_SECOND: begin
        if (hop_mod5_zero(item.hop_slot)) begin
          hdr = item.hop_slot[0] ? HDR_BIND_ODD : HDR_BIND_EVEN;
        end else begin
          hdr  = toggle_eff ? HDR_HALF_HI : HDR_HALF_LO;
          flip = 1'b1;
        end
      end
      default: begin
        hdr = item.hop_slot[0] ? HDR_THIRD_ODD : HDR_THIRD_EVN;
      end
    endcase
    toggle_nxt = flip ? ~toggle_eff : toggle_eff;

    // first channel: 4 + 6 * (hdr & 3), plus one when bit 3 is clear
    start = START_W'(4) + START_W'(6) * START_W'(hdr[1:0]) + START_W'(!hdr[3]);

    front_nxt.hdr  = hdr;
    front_nxt.seed = rev8(8'(item.hop_slot) + seed_offset);
    for (int i = 0; i < LANES; i++) begin
      logic [START_W-1:0] ch;
      ch = start - START_W'(2 * i);
      front_nxt.ok[i]  = (int'(ch) < SEND_CH_LIMIT) && (int'(ch) < NUM_RC_CHANNELS);
      front_nxt.raw[i] = store_r[CH_SEL_W'(ch)];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      toggle_r <= 1'b0;
      for (int i = 0; i < NUM_RC_CHANNELS; i++) begin
        store_r[i] <= '0;
      end
    end else begin
      if (wr_en && (int'(item.channel_index) < NUM_RC_CHANNELS)) begin
        store_r[widx] <= item.channel_value;
      end
      if (load_b) begin
        toggle_r <= toggle_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_b) begin
      front_r <= front_nxt;
    end
  end

endmodule

`default_nettype wire

// File: design/rcdf_scale.sv
// ----------------------------------------------------------------------------
// rcdf_scale
// Two-stage channel scaling lane: magnitude product, then reciprocal divide.
// ----------------------------------------------------------------------------
`default_nettype none

module rcdf_scale import rcdf_pkg::*; (
  input  wire logic             clk,
  input  wire pipe_en_t         en,
  input  wire logic [RAW_W-1:0] raw,
  input  wire logic             ok,
  output logic [VAL_W-1:0]      val
);

  logic signed [RAW_W:0] diff;
  logic              neg;
  logic [MAG_W-1:0]  mag;
  logic [NUM_W-1:0]  num_nxt;
  logic [NUM_W-1:0]  num_r;
  logic              neg_c_r, ok_c_r;
  logic [PROD_W-1:0] prod;
  logic [Q_W-1:0]    q_r;
  logic              neg_d_r, ok_d_r;

  always_comb begin
    diff    = $signed({1'b0, raw}) - $signed((RAW_W+1)'(CH_MIN_100));
    neg     = diff[RAW_W];
    mag     = neg ? MAG_W'(-diff) : MAG_W'(diff);
    num_nxt = NUM_W'(mag) * NUM_W'(SCALE_SPAN);
    prod    = PROD_W'(num_r) * PROD_W'(DIV_RECIP);
  end

  always_ff @(posedge clk) begin
    if (en.load_c) begin
      num_r   <= num_nxt;
      neg_c_r <= neg;
      ok_c_r  <= ok;
    end
    if (en.load_d) begin
      q_r     <= prod[DIV_SHIFT +: Q_W];
      neg_d_r <= neg_c_r;
      ok_d_r  <= ok_c_r;
    end
  end

  // truncation toward zero: subtract the magnitude quotient for negative offsets
  always_comb begin
    if (!ok_d_r) begin
      val = '0;
    end else if (neg_d_r) begin
      val = VAL_W'(OUT_LO) - VAL_W'(q_r);
    end else begin
      val = VAL_W'(OUT_LO) + VAL_W'(q_r);
    end
  end

endmodule

`default_nettype wire

// File: design/rcdf_serial.sv
// ----------------------------------------------------------------------------
// rcdf_serial
// Packet byte serializer; folds each sent header and channel byte into the CRC-8 on the way out.
// ----------------------------------------------------------------------------
`default_nettype none

module rcdf_serial import rcdf_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              load,
  input  wire pkt_t              pkt,
  input  wire logic [7:0]        crc_poly,
  input  wire logic              out_ready,
  output logic                   can_load,
  output logic                   out_valid,
  output logic [7:0]             out_packet_byte,
  output logic [BIDX_W-1:0]      out_byte_index,
  output logic                   out_last
);

  logic                         valid_r;
  logic [BIDX_W-1:0]            idx_r;
  logic [PKT_BYTES-2:0][7:0]    sh_r;
  logic [7:0]                   crc_r;
  logic                         take;
  logic                         at_last;

  function automatic logic [7:0] crc_step(input logic [7:0] crc,
                                          input logic [7:0] b,
                                          input logic [7:0] poly);
    logic [7:0] c;
    c = crc ^ b;
    for (int j = 0; j < 8; j++) begin
      c = c[7] ? ((c << 1) ^ poly) : (c << 1);
    end
    return c;
  endfunction

  assign at_last  = (idx_r == BIDX_W'(PKT_BYTES - 1));
  assign take     = valid_r && out_ready;
  assign can_load = !valid_r || (out_ready && at_last);

  assign out_valid       = valid_r;
  assign out_byte_index  = idx_r;
  assign out_last        = at_last;
  assign out_packet_byte = at_last ? rev8(crc_r) : sh_r[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= '0;
    end else if (load) begin
      valid_r <= 1'b1;
      idx_r   <= '0;
    end else if (take) begin
      if (at_last) begin
        valid_r <= 1'b0;
      end else begin
        idx_r <= idx_r + BIDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      sh_r[0] <= pkt.hdr;
      for (int i = 0; i < LANES; i++) begin
        sh_r[2*i+1] <= pkt.val[i][15:8];
        sh_r[2*i+2] <= pkt.val[i][7:0];
      end
      crc_r <= pkt.seed;
    end else if (take && !at_last) begin
      sh_r  <= sh_r >> 8;
      crc_r <= crc_step(crc_r, rev8(sh_r[0]), crc_poly);
    end
  end

endmodule

`default_nettype wire

// File: design/rc_data_packet_framer_core.sv
// ----------------------------------------------------------------------------
// rc_data_packet_framer_core
// Radio control data packet framer: channel store plus 8-byte packet builder.
// ----------------------------------------------------------------------------
// A transaction with func = 0 stores an 11-bit stick value and produces
// nothing. A transaction with func = 1 builds one packet (header,
// three big-endian scaled channels, CRC-8) and emits it as eight output
// transactions, byte_index 0..7, last set on the CRC byte. Input passes an
// input register, a header/store-read stage and two scaling stages (product,
// then reciprocal divide) before the byte serializer, which registers the
// packet and raises out_valid. The serializer sends one byte a cycle while
// out_ready is high, so sends are limited by the single output byte port;
// channel writes in between are absorbed one per cycle unless a stalled
// send holds the input register. Input is accepted while earlier packets
// are still in flight or being sent. The CRC is folded in byte by byte as
// bytes leave, using the crc_poly register, which has to be written by
// software after reset.
// Configuration writes are always ready and must happen while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module rc_data_packet_framer_core import rcdf_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // input channel
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic                  in_func,
  input  wire logic [IDX_W-1:0]      in_channel_index,
  input  wire logic [RAW_W-1:0]      in_channel_value,
  input  wire logic [PHASE_W-1:0]    in_phase,
  input  wire logic [HOP_W-1:0]      in_hop_slot,
  // result channel
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [7:0]                 out_packet_byte,
  output logic [BIDX_W-1:0]          out_byte_index,
  output logic                       out_last,
  // configuration write channel
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [7:0]            cfg_wdata
);

  // configuration registers
  logic [7:0] crc_poly_r;
  logic [7:0] seed_offset_r;

  // stage valids: a = input register, b = front, c/d = scaling
  logic   a_valid_r, b_valid_r, c_valid_r, d_valid_r;
  item_t  a_r;
  logic   a_adv, b_load, b_ready, c_ready, d_ready;
  pipe_en_t en;
  logic   ser_can_load, ser_load;

  front_t front_r;
  logic [7:0] hdr_c_r, seed_c_r, hdr_d_r, seed_d_r;
  pkt_t   pkt;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_poly_r    <= '0;
      seed_offset_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_CRC_POLY:    crc_poly_r    <= cfg_wdata;
        CFG_SEED_OFFSET: seed_offset_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Flow control: each stage moves when the next one is empty or moving.
  // Channel writes retire from the input register without entering the pipe.
  assign ser_load  = d_valid_r && ser_can_load;
  assign d_ready   = !d_valid_r || ser_can_load;
  assign c_ready   = !c_valid_r || d_ready;
  assign b_ready   = !b_valid_r || c_ready;
  assign en.load_c = b_valid_r && c_ready;
  assign en.load_d = c_valid_r && d_ready;
  assign a_adv     = a_valid_r && (!a_r.func || b_ready);
  assign b_load    = a_adv && a_r.func;
  assign in_ready  = !a_valid_r || a_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
      c_valid_r <= 1'b0;
      d_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        a_valid_r <= in_valid;
      end
      b_valid_r <= b_load    || (b_valid_r && !c_ready);
      c_valid_r <= en.load_c || (c_valid_r && !d_ready);
      d_valid_r <= en.load_d || (d_valid_r && !ser_load);
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      a_r.func          <= in_func;
      a_r.channel_index <= in_channel_index;
      a_r.channel_value <= in_channel_value;
      a_r.phase         <= in_phase;
      a_r.hop_slot      <= in_hop_slot;
    end
    if (en.load_c) begin
      hdr_c_r  <= front_r.hdr;
      seed_c_r <= front_r.seed;
    end
    if (en.load_d) begin
      hdr_d_r  <= hdr_c_r;
      seed_d_r <= seed_c_r;
    end
  end

  // header choice, toggle and channel store
  rcdf_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .item        (a_r),
    .wr_en       (a_adv && !a_r.func),
    .load_b      (b_load),
    .seed_offset (seed_offset_r),
    .front_r     (front_r)
  );

  // one scaling lane per transmitted channel
  for (genvar g = 0; g < LANES; g++) begin : g_lane
    rcdf_scale u_scale (
      .clk (clk),
      .en  (en),
      .raw (front_r.raw[g]),
      .ok  (front_r.ok[g]),
      .val (pkt.val[g])
    );
  end

  assign pkt.hdr  = hdr_d_r;
  assign pkt.seed = seed_d_r;

  rcdf_serial u_serial (
    .clk             (clk),
    .rst_n           (rst_n),
    .load            (ser_load),
    .pkt             (pkt),
    .crc_poly        (crc_poly_r),
    .out_ready       (out_ready),
    .can_load        (ser_can_load),
    .out_valid       (out_valid),
    .out_packet_byte (out_packet_byte),
    .out_byte_index  (out_byte_index),
    .out_last        (out_last)
  );

endmodule

`default_nettype wire

// File: design/rcdf_checker.sv
// ----------------------------------------------------------------------------
// rcdf_checker
// Port-level checks on packet byte sequencing of the framer.
// ----------------------------------------------------------------------------
`default_nettype none

module rcdf_checker import rcdf_pkg::*; (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_ready,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic [7:0]        out_packet_byte,
  input wire logic [BIDX_W-1:0] out_byte_index,
  input wire logic              out_last
);

  // after reset nothing is pending and input is open
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("framer not idle after reset");

  a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last == (out_byte_index == BIDX_W'(PKT_BYTES - 1))))
    else $error("last flag not on final byte");

  a_index_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |=>
      out_valid && (out_byte_index == $past(out_byte_index) + BIDX_W'(1)))
    else $error("packet byte skipped or dropped");

  a_new_packet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_last |=> !out_valid || (out_byte_index == '0))
    else $error("packet does not start at byte 0");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      out_valid && $stable(out_packet_byte) && $stable(out_byte_index))
    else $error("stalled output changed");

endmodule

bind rc_data_packet_framer_core rcdf_checker u_rcdf_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_packet_byte (out_packet_byte),
  .out_byte_index  (out_byte_index),
  .out_last        (out_last)
);

`default_nettype wire

// File: dv/rc_data_packet_framer_core_tb.sv
// ----------------------------------------------------------------------------
// rc_data_packet_framer_core_tb
// Self-checking bench for the data packet framer. Channel writes and send
// transactions go in over the valid/ready input port. A scoreboard class keeps
// its own copy of the channel store, the half toggle and the CRC registers.
// It predicts the eight bytes of every packet and checks each output
// transaction against the oldest expected byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rc_data_packet_framer_core_tb;
  import rcdf_pkg::*;

  localparam int CLK_PERIOD      = 4;
  localparam int RESET_CYCLES    = 4;
  localparam int TIMEOUT_CYCLES  = 500_000;
  // Wait this long past the last expected byte, so that a channel write still
  // in flight has retired, before reprogramming.
  localparam int SETTLE_CYCLES   = 16;
  localparam int RANDOM_PHASES   = 5;
  localparam int ITEMS_PER_PHASE = 88;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int HOLD_OFF_AFTER  = 150;
  localparam int MAX_PRINTED     = 100;

  typedef struct {
    logic               func;
    logic [IDX_W-1:0]   channel_index;
    logic [RAW_W-1:0]   channel_value;
    logic [PHASE_W-1:0] phase;
    logic [HOP_W-1:0]   hop_slot;
  } frame_item_t;

  typedef struct packed {
    logic [7:0]        data;
    logic [BIDX_W-1:0] idx;
    logic              last;
  } packet_byte_t;

  // --------------------------------------------------------------------------
  // Scoreboard: mirrors the framer state and holds the expected byte stream.
  // --------------------------------------------------------------------------
  class packet_byte_scoreboard;
    logic [RAW_W-1:0] chan_store [NUM_RC_CHANNELS];
    logic             half_toggle;
    logic [7:0]       poly;
    logic [7:0]       seed_ofs;
    packet_byte_t     expected_bytes [$];

    function new();
      foreach (chan_store[i]) chan_store[i] = '0;
      half_toggle = 1'b0;
      poly        = 8'h00;
      seed_ofs    = 8'h00;
    endfunction

    function int pending();
      return expected_bytes.size();
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] data);
      if (idx == CFG_CRC_POLY) poly = data;
      else if (idx == CFG_SEED_OFFSET) seed_ofs = data;
    endfunction

    function logic [7:0] bit_rev(logic [7:0] x);
      logic [7:0] r;
      for (int i = 0; i < 8; i++) r[i] = x[7-i];
      return r;
    endfunction

    // Maps -100..+100 percent onto 426..3448, truncating toward zero
    function logic [VAL_W-1:0] scaled(logic [RAW_W-1:0] raw);
      int d;
      int q;
      d = int'(raw) - CH_MIN_100;
      q = (d * SCALE_SPAN) / SCALE_DEN;
      return VAL_W'(q + OUT_LO);
    endfunction

    function void note_transaction(frame_item_t it);
      logic [7:0]       pkt [PKT_BYTES];
      logic [7:0]       hdr;
      logic [7:0]       crc;
      logic [VAL_W-1:0] v;
      int               start;
      packet_byte_t     e;
      if (!it.func) begin
        chan_store[it.channel_index] = it.channel_value;
        return;
      end
      if (it.hop_slot == 0) half_toggle = 1'b1;
      if (it.phase == PH_FIRST || (it.phase == PH_SECOND && (it.hop_slot % 5) == 0)) begin
        hdr = it.hop_slot[0] ? HDR_BIND_ODD : HDR_BIND_EVEN;
      end else if (it.phase == PH_SECOND) begin
        hdr = half_toggle ? HDR_HALF_HI : HDR_HALF_LO;
        half_toggle = ~half_toggle;
      end else begin
        // phase 2 and phase 3 both land in the third slot
        hdr = it.hop_slot[0] ? HDR_THIRD_ODD : HDR_THIRD_EVN;
      end
      pkt[0] = hdr;
      start = 4 + 6 * int'(hdr[1:0]) + (hdr[3] ? 0 : 1);
      for (int lane = 0; lane < LANES; lane++) begin
        v = '0;
        if (start < SEND_CH_LIMIT && start < NUM_RC_CHANNELS) v = scaled(chan_store[start]);
        start -= 2;
        pkt[lane*2+1] = v[15:8];
        pkt[lane*2+2] = v[7:0];
      end
      crc = 8'(it.hop_slot) + seed_ofs;
      crc = bit_rev(crc);
      for (int i = 0; i < PKT_BYTES - 1; i++) begin
        crc ^= bit_rev(pkt[i]);
        for (int j = 0; j < 8; j++) crc = crc[7] ? ((crc << 1) ^ poly) : (crc << 1);
      end
      pkt[PKT_BYTES-1] = bit_rev(crc);
      for (int i = 0; i < PKT_BYTES; i++) begin
        e.data = pkt[i];
        e.idx  = BIDX_W'(i);
        e.last = (i == PKT_BYTES - 1);
        expected_bytes.push_back(e);
      end
    endfunction

    // Returns an empty string on a match, else a description of the mismatch
    function string check_byte(logic [7:0] data, logic [BIDX_W-1:0] idx, logic last);
      packet_byte_t e;
      if (expected_bytes.size() == 0)
        return $sformatf("unexpected byte %02h idx %0d last %0b", data, idx, last);
      e = expected_bytes.pop_front();
      if (data !== e.data || idx !== e.idx || last !== e.last)
        return $sformatf("byte %02h/%02h idx %0d/%0d last %0b/%0b (got/exp)",
                         data, e.data, idx, e.idx, last, e.last);
      return "";
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // DUT signals
  // --------------------------------------------------------------------------
  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic                 in_func;
  logic [IDX_W-1:0]     in_channel_index;
  logic [RAW_W-1:0]     in_channel_value;
  logic [PHASE_W-1:0]   in_phase;
  logic [HOP_W-1:0]     in_hop_slot;
  logic                 out_valid;
  logic                 out_ready;
  logic [7:0]           out_packet_byte;
  logic [BIDX_W-1:0]    out_byte_index;
  logic                 out_last;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [7:0]           cfg_wdata;

  packet_byte_scoreboard sb = new();
  int error_count = 0;
  int burst_left  = 0;
  // Set by the result sink while it holds off; the sender drops its gaps then
  bit hold_active = 1'b0;
  // State of the well-formed hop sequence walk
  int seq_hop   = 0;
  int seq_phase = 0;

  rc_data_packet_framer_core DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_func          (in_func),
    .in_channel_index (in_channel_index),
    .in_channel_value (in_channel_value),
    .in_phase         (in_phase),
    .in_hop_slot      (in_hop_slot),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_packet_byte  (out_packet_byte),
    .out_byte_index   (out_byte_index),
    .out_last         (out_last),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Prints one line per mismatch (up to a cap) and counts every one
  task automatic report_mismatch(input string msg);
    error_count++;
    if (error_count <= MAX_PRINTED) $display("ERROR @%0t: %s", $time, msg);
  endtask

  // One config register write; valid stays up so writes can go back to back
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_reg(idx, data);
  endtask

  task automatic program_framer(input logic [7:0] poly, input logic [7:0] ofs);
    write_reg(CFG_CRC_POLY, poly);
    write_reg(CFG_SEED_OFFSET, ofs);
    cfg_valid <= 1'b0;
  endtask

  // Waits for every expected byte, then lets in-flight channel writes retire
  task automatic wait_drained();
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Offers one input transaction, holds it until accepted, then paces the
  // sender: bursts of random length separated by random gaps.
  task automatic push_item(input frame_item_t it);
    int gap;
    in_valid         <= 1'b1;
    in_func          <= it.func;
    in_channel_index <= it.channel_index;
    in_channel_value <= it.channel_value;
    in_phase         <= it.phase;
    in_hop_slot      <= it.hop_slot;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_transaction(it);
    if (burst_left > 0 || hold_active) begin
      if (burst_left > 0) burst_left--;
    end else begin
      gap        = $urandom_range(1, 12);
      burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(0, 24);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic logic [RAW_W-1:0] pick_value();
    case ($urandom_range(0, 11))
      0:       return 11'd0;
      1:       return 11'd2047;
      2:       return 11'(CH_MIN_100);
      3:       return 11'(CH_MAX_100);
      default: return 11'($urandom_range(0, 2047));
    endcase
  endfunction

  // Mostly a walk through the hop sequence (phases 0, 1, 2 per hop) with
  // channel writes mixed in; the rest is noise: random phase incl. 3 and
  // hop slots past the end of the sequence.
  task automatic run_random(input int count);
    frame_item_t it;
    int          r;
    for (int n = 0; n < count; n++) begin
      r                = $urandom_range(0, 99);
      it.channel_index = IDX_W'($urandom_range(0, 15));
      it.channel_value = pick_value();
      it.phase         = PHASE_W'($urandom_range(0, 3));
      it.hop_slot      = HOP_W'($urandom_range(0, 127));
      if (r < 35) begin
        it.func = 1'b0;
      end else if (r < 85) begin
        it.func = 1'b1;
        if ($urandom_range(0, 29) == 0) begin
          // broken sequence: jump somewhere in the hop table
          seq_hop   = $urandom_range(0, HOP_SLOTS - 1);
          seq_phase = $urandom_range(0, 2);
        end
        it.hop_slot = HOP_W'(seq_hop);
        it.phase    = PHASE_W'(seq_phase);
        if (seq_phase == 2 && $urandom_range(0, 19) == 0) it.phase = 2'd3;
        seq_phase++;
        if (seq_phase > 2) begin
          seq_phase = 0;
          seq_hop   = (seq_hop + 1) % HOP_SLOTS;
        end
      end else begin
        it.func = 1'b1;
      end
      push_item(it);
    end
    in_valid <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Result sink: checks every output transaction and drives out_ready in
  // changing stall modes, with one long hold-off to back up the pipeline.
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int    stall_mode;
    int    mode_cycles;
    int    hold_cycles;
    int    seen;
    bit    held;
    logic  rdy;
    string msg;
    stall_mode  = 0;
    mode_cycles = 0;
    hold_cycles = 0;
    seen        = 0;
    held        = 1'b0;
    rdy         = 1'b0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        msg = sb.check_byte(out_packet_byte, out_byte_index, out_last);
        if (msg != "") report_mismatch(msg);
        seen++;
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
        rdy = 1'b0;
      end else if (!held && seen >= HOLD_OFF_AFTER) begin
        held        = 1'b1;
        hold_cycles = HOLD_OFF_CYCLES;
        hold_active = 1'b1;
        rdy         = 1'b0;
      end else begin
        hold_active = 1'b0;
        if (mode_cycles == 0) begin
          stall_mode  = $urandom_range(0, 3);
          mode_cycles = $urandom_range(20, 200);
        end
        mode_cycles--;
        case (stall_mode)
          0:       rdy = 1'b1;
          1:       rdy = $urandom_range(0, 1);
          2:       rdy = ~rdy;
          default: rdy = ($urandom_range(0, 7) == 0);
        endcase
      end
      out_ready <= rdy;
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : main_seq
    frame_item_t it;
    int          dir_phase [10];
    int          dir_hop   [10];
    logic [7:0]  poly;
    logic [7:0]  ofs;
    // Directed sends: every header, toggle reset at hop 0, toggle flips,
    // phase 3, and a hop slot past the end of the sequence.
    dir_phase = '{0, 1, 1, 1, 1, 2, 2, 3, 0, 3};
    dir_hop   = '{0, 0, 1, 2, 3, 0, 1, 127, 77, 64};
    rst_n            <= 1'b0;
    in_valid         <= 1'b0;
    in_func          <= 1'b0;
    in_channel_index <= '0;
    in_channel_value <= '0;
    in_phase         <= '0;
    in_hop_slot      <= '0;
    cfg_valid        <= 1'b0;
    cfg_index        <= CFG_CRC_POLY;
    cfg_wdata        <= 8'h00;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    program_framer(8'h07, 8'h00);

    // Fill every channel with the range extremes
    for (int i = 0; i < NUM_RC_CHANNELS; i++) begin
      it.func          = 1'b0;
      it.channel_index = IDX_W'(i);
      case (i % 4)
        0:       it.channel_value = 11'd0;
        1:       it.channel_value = 11'd2047;
        2:       it.channel_value = 11'(CH_MIN_100);
        default: it.channel_value = 11'(CH_MAX_100);
      endcase
      it.phase    = PHASE_W'(i % 4);
      it.hop_slot = HOP_W'(i * 8);
      push_item(it);
    end
    for (int i = 0; i < 10; i++) begin
      it.func          = 1'b1;
      it.channel_index = IDX_W'(15 - i);
      it.channel_value = 11'(i * 200);
      it.phase         = PHASE_W'(dir_phase[i]);
      it.hop_slot      = HOP_W'(dir_hop[i]);
      push_item(it);
    end
    in_valid <= 1'b0;

    // Random phases, each under its own CRC setting, extremes first
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      wait_drained();
      case (p)
        0:       begin poly = 8'hFF; ofs = 8'hFF; end
        1:       begin poly = 8'h00; ofs = 8'($urandom_range(0, 255)); end
        2:       begin poly = 8'($urandom_range(0, 255)); ofs = 8'h00; end
        3:       begin poly = 8'h31; ofs = 8'($urandom_range(0, 255)); end
        default: begin poly = 8'($urandom_range(0, 255)); ofs = 8'($urandom_range(0, 255)); end
      endcase
      program_framer(poly, ofs);
      run_random(ITEMS_PER_PHASE);
    end

    wait_drained();
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog for a hung handshake
  initial begin : watchdog
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// File: rc_data_packet_framer_core.f
design/rcdf_pkg.sv
design/rcdf_front.sv
design/rcdf_scale.sv
design/rcdf_serial.sv
design/rc_data_packet_framer_core.sv
design/rcdf_checker.sv
dv/rc_data_packet_framer_core_tb.sv
